### design/kdeq_pkg.sv
// ----------------------------------------------------------------------------
// kdeq_pkg: shared types and constants of the key debounce event queue
// Holds the item action codes, the register indexes and the reset values.
// ----------------------------------------------------------------------------
package kdeq_pkg;

   typedef enum logic [1:0] {
      ACT_TICK = 2'd0,
      ACT_EDGE = 2'd1,
      ACT_POP  = 2'd2,
      ACT_PUSH = 2'd3
   } action_type;

   typedef enum logic {
      CSR_DEBOUNCE_MS       = 1'b0,
      CSR_HEALTH_TIMEOUT_MS = 1'b1
   } csr_index_type;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam logic [15:0] DEBOUNCE_MS_RESET = 16'd20;
   localparam logic [15:0] HEALTH_TIMEOUT_MS_RESET = 16'd200;
   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

endpackage

### design/key_debounce_event_queue.sv
// Result strobe: registered from the accepted transfer for ticks, edges and
// pushes; a pop passes through the pop wait register before its strobe.
// Throughput: one item per cycle, except a pop, which holds busy while the
// registered read of the queue memory completes.
// Reset: synchronous; the window closes, the queue empties and the registers
// return to 20 ms debounce and 200 ms health timeout.
// ----------------------------------------------------------------------------
// key_debounce_event_queue: three-key debouncer with a key event ring queue
// One shared debounce window samples the recorded key line after a set
// number of millisecond ticks and queues the logical key in a memory ring.
// ----------------------------------------------------------------------------
module key_debounce_event_queue
   import kdeq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [1:0]  req_edge_line,
   input  logic [2:0]  req_pin_levels,
   input  logic [7:0]  req_push_key,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_read_key,
   output logic        rsp_read_valid,
   output logic        rsp_key_queued,
   output logic [1:0]  rsp_queued_key,
   output logic        rsp_overwrote,
   output logic        rsp_healthy,
   output logic        rsp_debouncing,
   output logic [3:0]  rsp_queue_count,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W + 1)'(QUEUE_DEPTH);

   logic [7:0] queue_mem [QUEUE_DEPTH];
   logic [7:0] rd_data_ff;

   logic [15:0] debounce_ms_ff, health_timeout_ms_ff;
   logic        window_open_ff, window_open_in;
   logic [1:0]  pending_line_ff, pending_line_in;
   logic [15:0] elapsed_ms_ff, elapsed_ms_in;
   logic [PTR_W-1:0] write_ptr_ff, write_ptr_in;
   logic [PTR_W-1:0] read_ptr_ff, read_ptr_in;
   logic        pop_wait_ff;
   logic        strobe_ff;

   logic        read_valid_ff, read_valid_in;
   logic        key_queued_ff, key_queued_in;
   logic [1:0]  queued_key_ff, queued_key_in;
   logic        overwrote_ff, overwrote_in;
   logic        healthy_ff, healthy_in;
   logic [3:0]  queue_count_ff, queue_count_in;

   logic        accept;
   action_type  action;
   logic        push_en;
   logic [7:0]  push_data;
   logic        pop_en;
   logic [15:0] elapsed_inc;
   logic        pin_low;
   logic [PTR_W-1:0] write_next, read_next, read_after_push;
   logic [PTR_W:0]   count_full;
   logic [PTR_W+4:0] count_ext;

   assign accept = start && !busy;
   assign action = action_type'(req_action);
   assign busy = pop_wait_ff;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      ring_next = (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      case (pending_line_ff)
         2'd0: pin_low = !req_pin_levels[0];
         2'd1: pin_low = !req_pin_levels[1];
         2'd2: pin_low = !req_pin_levels[2];
         default: pin_low = 1'b0;
      endcase
   end

   assign elapsed_inc = (elapsed_ms_ff < ELAPSED_MAX) ? elapsed_ms_ff + 16'd1 : elapsed_ms_ff;
   assign write_next = ring_next(write_ptr_ff);
   assign read_next = ring_next(read_ptr_ff);

   always_comb begin
      window_open_in = window_open_ff;
      pending_line_in = pending_line_ff;
      elapsed_ms_in = elapsed_ms_ff;
      key_queued_in = 1'b0;
      queued_key_in = 2'd0;
      push_en = 1'b0;
      push_data = req_push_key;
      pop_en = 1'b0;
      read_valid_in = 1'b0;
      case (action)
         ACT_TICK: begin
            if (window_open_ff) begin
               elapsed_ms_in = elapsed_inc;
               if (elapsed_inc >= debounce_ms_ff) begin
                  if (pin_low) begin
                     queued_key_in = 2'd3 - pending_line_ff;
                     key_queued_in = 1'b1;
                     push_en = 1'b1;
                     push_data = {6'd0, queued_key_in};
                  end
                  window_open_in = 1'b0;
                  elapsed_ms_in = 16'd0;
               end
            end
         end
         ACT_EDGE: begin
            if (!window_open_ff && req_edge_line != 2'd3) begin
               window_open_in = 1'b1;
               pending_line_in = req_edge_line;
               elapsed_ms_in = 16'd0;
            end
         end
         ACT_POP: begin
            if (write_ptr_ff != read_ptr_ff) begin
               pop_en = 1'b1;
               read_valid_in = 1'b1;
            end
         end
         default: begin
            push_en = (req_push_key != 8'd0);
         end
      endcase
   end

   always_comb begin
      write_ptr_in = write_ptr_ff;
      read_ptr_in = read_ptr_ff;
      overwrote_in = 1'b0;
      read_after_push = (write_next == read_ptr_ff) ? read_next : read_ptr_ff;
      if (push_en) begin
         write_ptr_in = write_next;
         read_ptr_in = read_after_push;
         overwrote_in = (write_next == read_ptr_ff);
      end else if (pop_en) begin
         read_ptr_in = read_next;
      end
      healthy_in = !(window_open_in && (elapsed_ms_in > health_timeout_ms_ff));
      if (write_ptr_in >= read_ptr_in) begin
         count_full = {1'b0, write_ptr_in} - {1'b0, read_ptr_in};
      end else begin
         count_full = {1'b0, write_ptr_in} + DEPTH_EXT - {1'b0, read_ptr_in};
      end
      count_ext = {4'd0, count_full};
      queue_count_in = count_ext[3:0];
   end

   always_ff @(posedge clock) begin
      if (accept && push_en) begin
         queue_mem[write_ptr_ff] <= push_data;
      end
      if (accept && action == ACT_POP) begin
         rd_data_ff <= queue_mem[read_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= DEBOUNCE_MS_RESET;
         health_timeout_ms_ff <= HEALTH_TIMEOUT_MS_RESET;
         window_open_ff <= 1'b0;
         pending_line_ff <= 2'd0;
         elapsed_ms_ff <= 16'd0;
         write_ptr_ff <= '0;
         read_ptr_ff <= '0;
         pop_wait_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_DEBOUNCE_MS: debounce_ms_ff <= csr_write_data;
               CSR_HEALTH_TIMEOUT_MS: health_timeout_ms_ff <= csr_write_data;
               default: ;
            endcase
         end
         pop_wait_ff <= accept && (action == ACT_POP);
         strobe_ff <= pop_wait_ff || (accept && (action != ACT_POP));
         if (accept) begin
            window_open_ff <= window_open_in;
            pending_line_ff <= pending_line_in;
            elapsed_ms_ff <= elapsed_ms_in;
            write_ptr_ff <= write_ptr_in;
            read_ptr_ff <= read_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_valid_ff <= read_valid_in;
         key_queued_ff <= key_queued_in;
         queued_key_ff <= queued_key_in;
         overwrote_ff <= overwrote_in;
         healthy_ff <= healthy_in;
         queue_count_ff <= queue_count_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_read_key = read_valid_ff ? rd_data_ff : 8'd0;
   assign rsp_read_valid = read_valid_ff;
   assign rsp_key_queued = key_queued_ff;
   assign rsp_queued_key = queued_key_ff;
   assign rsp_overwrote = overwrote_ff;
   assign rsp_healthy = healthy_ff;
   assign rsp_debouncing = window_open_ff;
   assign rsp_queue_count = queue_count_ff;

   a_pop_wait_one_cycle: assert property (@(posedge clock) disable iff (reset)
      pop_wait_ff |=> !pop_wait_ff && strobe_ff)
      else $error("pop wait did not end in a result transfer");

   a_non_pop_result: assert property (@(posedge clock) disable iff (reset)
      (accept && action != ACT_POP) |=> strobe_ff && !read_valid_ff)
      else $error("non-pop item did not give a result in the next cycle");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (write_ptr_ff <= PTR_LAST) && (read_ptr_ff <= PTR_LAST))
      else $error("queue pointer outside the ring");

   a_push_never_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && push_en) |=> write_ptr_ff != read_ptr_ff)
      else $error("queue empty right after a push");

endmodule

### dv/tb_key_debounce_event_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_debounce_event_queue: self-checking bench for the key debouncer
// Directed and random ticks, edges, pops and pushes are sent under several
// register settings. Every transfer is mirrored in a local model of the
// debounce window and key ring, and each result strobe is compared with it.
// ----------------------------------------------------------------------------
module tb_key_debounce_event_queue;
   import kdeq_pkg::*;

   localparam int RING_SIZE   = QUEUE_DEPTH_DEFAULT;
   localparam int STALL_LIMIT = 1000;
   localparam int END_LIMIT   = 200;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [7:0] read_key;
      logic       read_valid;
      logic       key_queued;
      logic [1:0] queued_key;
      logic       overwrote;
      logic       healthy;
      logic       debouncing;
      logic [3:0] queue_count;
   } key_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_action;
   logic [1:0]  req_edge_line;
   logic [2:0]  req_pin_levels;
   logic [7:0]  req_push_key;
   logic        rsp_strobe;
   logic [7:0]  rsp_read_key;
   logic        rsp_read_valid;
   logic        rsp_key_queued;
   logic [1:0]  rsp_queued_key;
   logic        rsp_overwrote;
   logic        rsp_healthy;
   logic        rsp_debouncing;
   logic [3:0]  rsp_queue_count;
   logic        csr_write_enable;
   logic        csr_index;
   logic [15:0] csr_write_data;

   logic        win_open;
   logic [1:0]  win_line;
   logic [15:0] win_elapsed;
   logic [7:0]  key_ring [RING_SIZE];
   logic [3:0]  ring_wr;
   logic [3:0]  ring_rd;
   logic [15:0] debounce_setting;
   logic [15:0] timeout_setting;

   key_result_type pending_results [$];
   int          mismatches;
   int          stall_cycles;
   bit          gap_enable;

   key_debounce_event_queue dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_edge_line    (req_edge_line),
      .req_pin_levels   (req_pin_levels),
      .req_push_key     (req_push_key),
      .rsp_strobe       (rsp_strobe),
      .rsp_read_key     (rsp_read_key),
      .rsp_read_valid   (rsp_read_valid),
      .rsp_key_queued   (rsp_key_queued),
      .rsp_queued_key   (rsp_queued_key),
      .rsp_overwrote    (rsp_overwrote),
      .rsp_healthy      (rsp_healthy),
      .rsp_debouncing   (rsp_debouncing),
      .rsp_queue_count  (rsp_queue_count),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic ring_insert(input logic [7:0] value);
      logic [3:0] next_wr;
      logic       dropped;
      next_wr = ring_wr + 4'd1;
      dropped = 1'b0;
      if (next_wr == ring_rd) begin
         ring_rd = ring_rd + 4'd1;
         dropped = 1'b1;
      end
      key_ring[ring_wr] = value;
      ring_wr = next_wr;
      return dropped;
   endfunction

   task automatic predict_key_event(input action_type act, input logic [1:0] line,
                                    input logic [2:0] pins, input logic [7:0] key);
      key_result_type r;
      r = '0;
      r.healthy = 1'b1;
      case (act)
         ACT_TICK: begin
            if (win_open) begin
               if (win_elapsed != ELAPSED_MAX)
                  win_elapsed = win_elapsed + 16'd1;
               if (win_elapsed >= debounce_setting) begin
                  if (pins[win_line] == 1'b0) begin
                     r.queued_key = 2'd3 - win_line;
                     r.key_queued = 1'b1;
                     r.overwrote  = ring_insert({6'd0, r.queued_key});
                  end
                  win_open = 1'b0;
                  win_elapsed = 16'd0;
               end
            end
         end
         ACT_EDGE: begin
            if (!win_open && line != 2'd3) begin
               win_open = 1'b1;
               win_line = line;
               win_elapsed = 16'd0;
            end
         end
         ACT_POP: begin
            if (ring_wr != ring_rd) begin
               r.read_key   = key_ring[ring_rd];
               r.read_valid = 1'b1;
               ring_rd = ring_rd + 4'd1;
            end
         end
         default: begin
            if (key != 8'd0)
               r.overwrote = ring_insert(key);
         end
      endcase
      if (win_open && win_elapsed > timeout_setting)
         r.healthy = 1'b0;
      r.debouncing  = win_open;
      r.queue_count = ring_wr - ring_rd;
      pending_results.push_back(r);
   endtask

   task automatic send_item(input action_type act, input logic [1:0] line,
                            input logic [2:0] pins, input logic [7:0] key);
      int gap;
      gap = gap_enable ? int'($urandom_range(0, 8)) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_action     <= act;
      req_edge_line  <= line;
      req_pin_levels <= pins;
      req_push_key   <= key;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      predict_key_event(act, line, pins, key);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_regs(input logic [15:0] debounce, input logic [15:0] timeout);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DEBOUNCE_MS;
      csr_write_data   <= debounce;
      @(posedge clock);
      debounce_setting = debounce;
      csr_index        <= CSR_HEALTH_TIMEOUT_MS;
      csr_write_data   <= timeout;
      @(posedge clock);
      timeout_setting  = timeout;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed();
      write_regs(16'd1, 16'hFFFF);
      send_item(ACT_POP, 2'd0, 3'd7, 8'd0);
      send_item(ACT_PUSH, 2'd0, 3'd7, 8'h00);
      send_item(ACT_PUSH, 2'd3, 3'd7, 8'hFF);
      send_item(ACT_PUSH, 2'd0, 3'd7, 8'h01);
      repeat (3) send_item(ACT_POP, 2'd0, 3'd0, 8'd0);
      send_item(ACT_TICK, 2'd0, 3'd0, 8'd0);
      send_item(ACT_EDGE, 2'd3, 3'd7, 8'd0);
      send_item(ACT_EDGE, 2'd0, 3'd7, 8'd0);
      send_item(ACT_EDGE, 2'd2, 3'd7, 8'd0);
      send_item(ACT_TICK, 2'd0, 3'b110, 8'd0);
      send_item(ACT_EDGE, 2'd1, 3'd7, 8'd0);
      send_item(ACT_TICK, 2'd0, 3'b111, 8'd0);
      send_item(ACT_EDGE, 2'd2, 3'd7, 8'd0);
      send_item(ACT_TICK, 2'd0, 3'b011, 8'd0);
      send_item(ACT_EDGE, 2'd1, 3'd7, 8'd0);
      send_item(ACT_TICK, 2'd0, 3'b101, 8'd0);
      repeat (3) send_item(ACT_POP, 2'd0, 3'd7, 8'd0);
      write_regs(16'd0, 16'd0);
      send_item(ACT_EDGE, 2'd1, 3'd7, 8'd0);
      send_item(ACT_TICK, 2'd0, 3'b000, 8'd0);
      send_item(ACT_POP, 2'd0, 3'd7, 8'd0);
   endtask

   task automatic test_queue_wrap();
      write_regs(16'd1, 16'hFFFF);
      repeat (RING_SIZE + 2)
         send_item(ACT_PUSH, 2'($urandom()), 3'($urandom()), 8'($urandom_range(1, 255)));
      send_item(ACT_EDGE, 2'd0, 3'd7, 8'd0);
      send_item(ACT_TICK, 2'd0, 3'b000, 8'd0);
      repeat (RING_SIZE) send_item(ACT_POP, 2'd0, 3'd7, 8'd0);
   endtask

   task automatic test_health_timeout();
      write_regs(16'd5, 16'd2);
      send_item(ACT_EDGE, 2'd0, 3'd7, 8'd0);
      repeat (5) send_item(ACT_TICK, 2'd0, 3'b111, 8'd0);
      write_regs(16'd4, 16'd0);
      send_item(ACT_EDGE, 2'd1, 3'd7, 8'd0);
      repeat (4) send_item(ACT_TICK, 2'd0, 3'b000, 8'd0);
      send_item(ACT_POP, 2'd0, 3'd7, 8'd0);
   endtask

   task automatic test_long_window();
      bit saved_gap;
      saved_gap = gap_enable;
      gap_enable = 1'b0;
      write_regs(16'd60, 16'd40);
      send_item(ACT_EDGE, 2'd2, 3'd7, 8'd0);
      repeat (60) send_item(ACT_TICK, 2'd0, 3'b000, 8'd0);
      send_item(ACT_POP, 2'd0, 3'd7, 8'd0);
      gap_enable = saved_gap;
   endtask

   task automatic test_random(input logic [15:0] debounce, input logic [15:0] timeout,
                              input int count, input int pop_pct);
      int         pick;
      action_type act;
      logic [7:0] key;
      write_regs(debounce, timeout);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0)
            gap_enable = $urandom_range(0, 1);
         if ($urandom_range(0, 59) == 0)
            drain_results();
         pick = $urandom_range(0, 99);
         if (pick < pop_pct)
            act = ACT_POP;
         else if (pick < pop_pct + 20)
            act = ACT_PUSH;
         else if (pick < pop_pct + 40)
            act = ACT_EDGE;
         else
            act = ACT_TICK;
         key = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom());
         send_item(act, 2'($urandom()), 3'($urandom()), key);
      end
   endtask

   function automatic string format_result(input key_result_type r);
      return $sformatf("key=%0d valid=%0d queued=%0d/%0d over=%0d healthy=%0d deb=%0d count=%0d",
                       r.read_key, r.read_valid, r.key_queued, r.queued_key, r.overwrote,
                       r.healthy, r.debouncing, r.queue_count);
   endfunction

   always @(posedge clock) begin : check_results
      key_result_type got;
      key_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         got.read_key    = rsp_read_key;
         got.read_valid  = rsp_read_valid;
         got.key_queued  = rsp_key_queued;
         got.queued_key  = rsp_queued_key;
         got.overwrote   = rsp_overwrote;
         got.healthy     = rsp_healthy;
         got.debouncing  = rsp_debouncing;
         got.queue_count = rsp_queue_count;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: %s", format_result(got));
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("mismatch expected: %s", format_result(want));
                  $display("         actual:   %s", format_result(got));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe === 1'b1)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_key_debounce_event_queue: errors");
         $finish;
      end
   end

   initial begin
      int waited;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_action       <= ACT_TICK;
      req_edge_line    <= 2'd0;
      req_pin_levels   <= 3'd7;
      req_push_key     <= 8'd0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_DEBOUNCE_MS;
      csr_write_data   <= 16'd0;
      win_open         = 1'b0;
      win_line         = 2'd0;
      win_elapsed      = 16'd0;
      ring_wr          = 4'd0;
      ring_rd          = 4'd0;
      debounce_setting = DEBOUNCE_MS_RESET;
      timeout_setting  = HEALTH_TIMEOUT_MS_RESET;
      mismatches       = 0;
      stall_cycles     = 0;
      gap_enable       = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_random(DEBOUNCE_MS_RESET, HEALTH_TIMEOUT_MS_RESET, 200, 20);
      test_directed();
      test_queue_wrap();
      test_health_timeout();
      test_long_window();
      test_random(16'd3, 16'd1, 250, 8);
      test_random(16'd1, 16'd0, 200, 30);
      test_random(16'd0, 16'hFFFF, 150, 20);
      test_random(16'd7, 16'd4, 250, 10);
      test_random(16'd2, 16'hFFFF, 150, 25);

      start <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < END_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      mismatches += pending_results.size();
      if (mismatches == 0)
         $display("tb_key_debounce_event_queue: clean");
      else
         $display("tb_key_debounce_event_queue: errors");
      $finish;
   end

endmodule
